// ----- rtl/fba_pkg.sv -----
// Package: shared types, constants and codes for the frame bitmap allocator.
`timescale 1ns / 1ps
package fba_pkg;

    localparam int MAX_FRAMES   = 4096;
    localparam int WORD_BITS    = 32;
    localparam int WORD_COUNT   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W       = $clog2(WORD_COUNT);
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int FRAME_W      = 12;
    localparam int CNT_W        = 13;
    localparam int FIELD_FRAMES = 4096;
    localparam int LIMIT_MAX    = (MAX_FRAMES < FIELD_FRAMES) ? MAX_FRAMES : FIELD_FRAMES;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;
    localparam logic [1:0] OP_ALT   = 2'd3;

    localparam logic [2:0] ST_ALLOCATED = 3'd0;
    localparam logic [2:0] ST_MAPPED    = 3'd1;
    localparam logic [2:0] ST_NO_FREE   = 3'd2;
    localparam logic [2:0] ST_FREED     = 3'd3;
    localparam logic [2:0] ST_NOTHING   = 3'd4;
    localparam logic [2:0] ST_TESTED    = 3'd5;

    typedef struct packed {
        logic [1:0]         operation;
        logic [FRAME_W-1:0] frame_index;
        logic               kernel_mode;
        logic               is_writable;
    } t_fba_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [FRAME_W-1:0] result_frame;
        logic               present_flag;
        logic               writable_flag;
        logic               user_flag;
        logic               frame_in_use;
    } t_fba_out;

    typedef struct packed {
        logic load;
        logic step;
        logic capture;
        logic write;
    } t_fba_cmd;

    typedef struct packed {
        logic finish;
        logic write;
    } t_fba_stat;

endpackage

// ----- rtl/fba_ctrl.sv -----
// Controller: sequences load, word fetch and evaluation of one word.
`timescale 1ns / 1ps
module fba_ctrl
    import fba_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    output logic      o_busy,
    output t_fba_cmd  o_cmd,
    input  t_fba_stat i_stat
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.step    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.write   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.step = 1'b1;
                n_state    = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.step = 1'b1;
                if (i_stat.finish) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.write   = i_stat.write;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- rtl/fba_datapath.sv -----
// Datapath: bitmap memory, word scan, limit register and result register.
`timescale 1ns / 1ps
module fba_datapath
    import fba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_fba_cmd         i_cmd,
    output t_fba_stat        o_stat,
    input  t_fba_in          i_word,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    output logic             o_result_valid,
    output t_fba_out         o_result
);

    function automatic logic [BIT_W-1:0] low_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!w[b]) idx = BIT_W'(b);
        end
        return idx;
    endfunction

    logic [WORD_BITS-1:0]  r_mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] r_valid;
    logic [WORD_BITS-1:0]  r_rd_word;
    logic                  r_rd_vld;
    logic [ADDR_W-1:0]     r_rd_addr;
    logic [ADDR_W-1:0]     r_data_addr;
    logic [CNT_W-1:0]      r_frame_count;
    t_fba_in               r_item;
    t_fba_out              r_result;
    logic                  r_result_valid;

    logic [WORD_BITS-1:0]  word;
    logic [CNT_W-1:0]      limit;
    logic [CNT_W-1:0]      base;
    logic [BIT_W-1:0]      zero_bit;
    logic [CNT_W-1:0]      cand;
    logic                  have_zero;
    logic                  is_scan;
    logic                  found;
    logic                  fail;
    logic [BIT_W-1:0]      sel_bit;
    logic [WORD_BITS-1:0]  n_word;
    t_fba_out              n_result;

    assign word      = r_rd_vld ? r_rd_word : '0;
    assign limit     = (r_frame_count > CNT_W'(LIMIT_MAX)) ? CNT_W'(LIMIT_MAX) : r_frame_count;
    assign base      = CNT_W'({r_data_addr, {BIT_W{1'b0}}});
    assign have_zero = ~&word;
    assign zero_bit  = low_zero(word);
    assign cand      = base + CNT_W'(zero_bit);
    assign is_scan   = (r_item.operation == OP_ALLOC) && (r_item.frame_index == '0);
    assign found     = (base < limit) && have_zero && (cand < limit);
    assign fail      = (base >= limit) || (have_zero && (cand >= limit))
                     || (!have_zero && (r_data_addr == ADDR_W'(WORD_COUNT - 1)));
    assign sel_bit   = r_item.frame_index[BIT_W-1:0];

    always_comb begin
        n_result        = '0;
        n_word          = word & ~(WORD_BITS'(1) << sel_bit);
        o_stat.finish   = 1'b1;
        o_stat.write    = 1'b0;
        case (r_item.operation)
            OP_ALLOC: begin
                if (!is_scan) begin
                    n_result.status       = ST_MAPPED;
                    n_result.result_frame = r_item.frame_index;
                end else begin
                    n_word        = word | (WORD_BITS'(1) << zero_bit);
                    o_stat.finish = found || fail;
                    o_stat.write  = found;
                    if (found) begin
                        n_result.status        = ST_ALLOCATED;
                        n_result.result_frame  = cand[FRAME_W-1:0];
                        n_result.present_flag  = 1'b1;
                        n_result.writable_flag = r_item.is_writable;
                        n_result.user_flag     = ~r_item.kernel_mode;
                    end else begin
                        n_result.status = ST_NO_FREE;
                    end
                end
            end
            OP_FREE: begin
                if (r_item.frame_index == '0) begin
                    n_result.status = ST_NOTHING;
                end else begin
                    n_result.status = ST_FREED;
                    o_stat.write    = 1'b1;
                end
            end
            default: begin
                n_result.status       = ST_TESTED;
                n_result.result_frame = r_item.frame_index;
                n_result.frame_in_use = word[sel_bit];
            end
        endcase
    end

    // bitmap storage, one word read per cycle
    always_ff @(posedge i_clk) begin
        r_rd_word   <= r_mem[r_rd_addr];
        r_data_addr <= r_rd_addr;
        if (i_cmd.write) begin
            r_mem[r_data_addr] <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= '0;
            r_rd_vld       <= 1'b0;
            r_frame_count  <= CNT_W'(4096);
            r_result_valid <= 1'b0;
        end else begin
            r_rd_vld       <= r_valid[r_rd_addr];
            r_result_valid <= i_cmd.capture;
            if (i_cmd.write) begin
                r_valid[r_data_addr] <= 1'b1;
            end
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_word;
            if ((i_word.operation == OP_ALLOC) && (i_word.frame_index == '0)) begin
                r_rd_addr <= '0;
            end else begin
                r_rd_addr <= i_word.frame_index[FRAME_W-1:BIT_W];
            end
        end else if (i_cmd.step) begin
            r_rd_addr <= r_rd_addr + ADDR_W'(1);
        end
        if (i_cmd.capture) begin
            r_result <= n_result;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

// ----- rtl/frame_bitmap_allocator_core.sv -----
// Top level: first-fit bitmap frame allocator with command-style handshake.
//
// Usage: drive i_cmd and raise start; the word is taken at a clock edge
// where start is high and busy is low. Operations are allocate, free and
// test (code 3 acts as test). Each word yields one result, shown on
// o_result for exactly one cycle with o_result_valid high; the receiver
// cannot stall, so the result must be taken in that cycle.
// Free, test and allocate of an already mapped entry fetch one bitmap word
// (FETCH state), evaluate it (EVAL state) and register the result strobe.
// An allocate that searches reads one bitmap word per cycle from the bitmap
// memory until it finds a free frame below frame_count or fails; the scan
// can run through all 128 words. busy falls with the strobe, so the next word
// may be accepted at the edge that ends the result cycle.
// i_cfg_we/i_cfg_wdata write frame_count (frames at or above it are never
// allocated); write only while busy is low.
// Reset (synchronous, active low) marks every frame free at once and sets
// frame_count to 4096.
`timescale 1ns / 1ps
module frame_bitmap_allocator_core
    import fba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_fba_in          i_cmd,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    output logic             o_result_valid,
    output t_fba_out         o_result
);

    t_fba_cmd  cmd;
    t_fba_stat stat;

    fba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    fba_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_word         (i_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(busy) && !busy))
        else $error("result strobe without a finished word");

    a_alloc_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status != ST_ALLOCATED)) |->
        (!o_result.present_flag && !o_result.writable_flag && !o_result.user_flag))
        else $error("flags set without an allocation");

    a_alloc_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status == ST_ALLOCATED)) |-> o_result.present_flag)
        else $error("allocation without present flag");

endmodule
